@@ hw/rtl/adb_key_report_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// adb_key_report_decoder_defines.svh
// Assertion macros shared by the key report decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ADB_KEY_REPORT_DECODER_DEFINES_SVH
`define ADB_KEY_REPORT_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define AKRD_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("akrd: same-cycle check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define AKRD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("akrd: next-cycle check failed");

`endif

@@ hw/rtl/akrd_pkg.sv @@
// ----------------------------------------------------------------------------
// akrd_pkg
// Types and constants of the key report decoder.
// ----------------------------------------------------------------------------
package akrd_pkg;

	// configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [2:0] REG_PLAIN_KEYS      = 3'd0;
	localparam logic [2:0] REG_REPEAT_DELAY    = 3'd1;
	localparam logic [2:0] REG_REPEAT_PERIOD   = 3'd2;
	localparam logic [2:0] REG_EMULATE_BUTTONS = 3'd3;
	localparam logic [2:0] REG_BUTTON2_KEY     = 3'd4;
	localparam logic [2:0] REG_BUTTON3_KEY     = 3'd5;

	// reset values
	localparam logic [15:0] RST_REPEAT_DELAY  = 16'd50;
	localparam logic [15:0] RST_REPEAT_PERIOD = 16'd6;
	localparam logic [6:0]  RST_BUTTON2_KEY   = 7'h7d;
	localparam logic [6:0]  RST_BUTTON3_KEY   = 7'h7c;

	// packet framing
	localparam logic [3:0] PKT_BYTES   = 4'd3;
	localparam logic [1:0] PKT_REG_KEY = 2'd0;
	localparam logic       MODE_PACKET = 1'b0;
	localparam logic       MODE_TICK   = 1'b1;

	// key codes
	localparam logic [6:0] KEY_ALIAS       = 7'h7e;
	localparam logic [6:0] KEY_MAPPED      = 7'h7f;
	localparam logic [6:0] KEY_CAPS_LOCK   = 7'h39;
	localparam logic [7:0] SCAN_CAPS_PRESS = 8'h39;
	localparam logic [7:0] SCAN_CAPS_REL   = 8'hb9;
	localparam logic [7:0] SCAN_NONE       = 8'hff;
	localparam logic [7:0] SCAN_IDLE       = 8'h7f;

	// result kinds and button numbers
	localparam logic       KIND_KEY    = 1'b0;
	localparam logic       KIND_BUTTON = 1'b1;
	localparam logic [1:0] BTN_NONE    = 2'd0;
	localparam logic [1:0] BTN_TWO     = 2'd2;
	localparam logic [1:0] BTN_THREE   = 2'd3;

	// keys that never autorepeat, one bit per key code
	localparam logic [127:0] NO_REPEAT_ROM =
		(128'd1 << 8'h35) | (128'd1 << 8'h36) | (128'd1 << 8'h37) |
		(128'd1 << 8'h38) | (128'd1 << 8'h39) | (128'd1 << 8'h3a) |
		(128'd1 << 8'h47) | (128'd1 << 8'h6b);

	// results per input item
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = 2;
	localparam int RES_CNT_W = 3;

	// bundle queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic       mode;
		logic [3:0] byte_count;
		logic [7:0] header_byte;
		logic [7:0] key_byte1;
		logic [7:0] key_byte2;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] scan_code;
		logic [1:0] button_number;
		logic       button_released;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic        plain_keys;
		logic [15:0] repeat_delay;
		logic [15:0] repeat_period;
		logic        emulate_buttons;
		logic [6:0]  button2_key;
		logic [6:0]  button3_key;
	} cfg_t;

	// all results of one input item, in order, last one flagged
	typedef struct packed {
		out_item_t [MAX_RES-1:0] res;
		logic [RES_CNT_W-1:0]    count;
	} bundle_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

endpackage

@@ hw/rtl/akrd_front.sv @@
// ----------------------------------------------------------------------------
// akrd_front
// Accepts packets and ticks, runs key decode and repeat state, builds bundles.
// ----------------------------------------------------------------------------
module akrd_front #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  akrd_pkg::in_item_t in_data,
	input  akrd_pkg::cfg_t     cfg,
	input  akrd_pkg::q_status_t q_stat,
	output logic               push,
	output akrd_pkg::bundle_t  push_data
);
	import akrd_pkg::*;

	localparam logic [32:0] CNT_MAX = (33'd1 << TICK_COUNT_WIDTH) - 33'd1;
	localparam logic [TICK_COUNT_WIDTH-1:0] CNT_ONE = TICK_COUNT_WIDTH'(1);

	typedef struct packed {
		logic                        armed;
		logic [TICK_COUNT_WIDTH-1:0] count;
		logic [6:0]                  key;
		logic                        b2_up;
		logic                        b3_up;
	} kstate_t;

	typedef struct packed {
		kstate_t             st;
		out_item_t [1:0]     res;
		logic [1:0]          n;
	} dec_t;

	kstate_t st_q;
	kstate_t st_nxt;
	bundle_t bnd;
	logic    accept;

	// clamp a register value into the counter range, zero counts as one
	function automatic logic [TICK_COUNT_WIDTH-1:0] cnt_load(input logic [15:0] v);
		logic [32:0] ext;
		ext = {17'd0, v};
		if (ext > CNT_MAX)
			ext = CNT_MAX;
		if (ext == 33'd0)
			ext = 33'd1;
		return ext[TICK_COUNT_WIDTH-1:0];
	endfunction

	function automatic out_item_t key_res(input logic [7:0] code);
		out_item_t r;
		r = '0;
		r.kind = KIND_KEY;
		r.scan_code = code;
		r.button_number = BTN_NONE;
		return r;
	endfunction

	function automatic out_item_t btn_res(input logic [1:0] num, input logic rel);
		out_item_t r;
		r = '0;
		r.kind = KIND_BUTTON;
		r.button_number = num;
		r.button_released = rel;
		return r;
	endfunction

	// one key code: button emulation, repeat arming, caps lock pair
	function automatic dec_t dec_key(input logic [7:0] code, input logic rpt,
			input kstate_t st, input cfg_t c);
		dec_t d;
		logic up;
		logic [6:0] k;
		d = '0;
		d.st = st;
		up = code[7];
		k = code[6:0];
		if (k == KEY_ALIAS)
			k = KEY_MAPPED;
		if (!rpt)
			d.st.armed = 1'b0;
		if (c.emulate_buttons && (k == c.button2_key || k == c.button3_key)) begin
			if (k == c.button2_key) begin
				if (d.st.b2_up != up) begin
					d.st.b2_up = up;
					d.res[0] = btn_res(BTN_TWO, up);
					d.n = 2'd1;
				end
			end else begin
				if (d.st.b3_up != up) begin
					d.st.b3_up = up;
					d.res[0] = btn_res(BTN_THREE, up);
					d.n = 2'd1;
				end
			end
		end else if (!c.plain_keys && k == KEY_CAPS_LOCK) begin
			d.res[0] = key_res(SCAN_CAPS_PRESS);
			d.res[1] = key_res(SCAN_CAPS_REL);
			d.n = 2'd2;
		end else begin
			d.res[0] = key_res({up, k});
			d.n = 2'd1;
		end
		// arming is independent of the emitted form, but not of button keys
		if (!c.plain_keys && !up && !NO_REPEAT_ROM[k] &&
				!(c.emulate_buttons && (k == c.button2_key || k == c.button3_key))) begin
			d.st.key = k;
			d.st.count = cnt_load(rpt ? c.repeat_period : c.repeat_delay);
			d.st.armed = 1'b1;
		end
		return d;
	endfunction

	assign in_ready = !q_stat.full;
	assign accept = in_valid && in_ready;

	always_comb begin
		dec_t d1;
		dec_t d2;
		kstate_t s;
		logic [RES_CNT_W-1:0] n;
		d1 = '0;
		d2 = '0;
		s = st_q;
		bnd = '0;
		if (in_data.mode == MODE_TICK) begin
			if (st_q.armed) begin
				if (st_q.count <= CNT_ONE) begin
					s.count = '0;
					s.armed = 1'b0;
					d1 = dec_key({1'b0, st_q.key}, 1'b1, s, cfg);
					s = d1.st;
				end else begin
					s.count = st_q.count - CNT_ONE;
				end
			end
		end else if (in_data.byte_count == PKT_BYTES &&
				in_data.header_byte[1:0] == PKT_REG_KEY) begin
			d1 = dec_key(in_data.key_byte1, 1'b0, s, cfg);
			s = d1.st;
			if (!(in_data.key_byte2 == SCAN_NONE ||
					(in_data.key_byte2 == SCAN_IDLE && in_data.key_byte1 == SCAN_IDLE))) begin
				d2 = dec_key(in_data.key_byte2, 1'b0, s, cfg);
				s = d2.st;
			end
		end
		for (int j = 0; j < 2; j++) begin
			if (2'(j) < d1.n)
				bnd.res[j] = d1.res[j];
			if (2'(j) < d2.n)
				bnd.res[RES_IDX_W'(d1.n) + RES_IDX_W'(j)] = d2.res[j];
		end
		n = RES_CNT_W'(d1.n) + RES_CNT_W'(d2.n);
		bnd.count = n;
		if (n != '0)
			bnd.res[RES_IDX_W'(n - RES_CNT_W'(1))].last = 1'b1;
		st_nxt = s;
	end

	assign push = accept && (bnd.count != '0);
	assign push_data = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.armed <= 1'b0;
			st_q.count <= '0;
			st_q.key <= '0;
			st_q.b2_up <= 1'b1;
			st_q.b3_up <= 1'b1;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

endmodule

@@ hw/rtl/akrd_queue.sv @@
// ----------------------------------------------------------------------------
// akrd_queue
// Short bundle queue between front and back.
// ----------------------------------------------------------------------------
module akrd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  akrd_pkg::bundle_t   push_data,
	input  logic                pop,
	output akrd_pkg::bundle_t   head,
	output akrd_pkg::q_status_t q_stat
);
	import akrd_pkg::*;

	bundle_t             mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign head = mem[rd_ptr_q];
	assign q_stat.full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.nonempty = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/akrd_back.sv @@
// ----------------------------------------------------------------------------
// akrd_back
// Walks each queued bundle and hands results out one per transfer.
// ----------------------------------------------------------------------------
module akrd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  akrd_pkg::bundle_t   head,
	input  akrd_pkg::q_status_t q_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output akrd_pkg::out_item_t out_data
);
	import akrd_pkg::*;

	out_item_t            out_q;
	logic                 out_valid_q;
	logic [RES_IDX_W-1:0] idx_q;
	logic                 load;
	logic                 at_end;

	assign load = q_stat.nonempty && (!out_valid_q || out_ready);
	assign at_end = ({1'b0, idx_q} == (head.count - RES_CNT_W'(1)));
	assign pop = load && at_end;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (load)
			out_q <= head.res[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= at_end ? '0 : idx_q + RES_IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/adb_key_report_decoder.sv @@
// ----------------------------------------------------------------------------
// adb_key_report_decoder
// Keyboard register 0 reply decoder with typematic repeat and button keys.
// ----------------------------------------------------------------------------
// Each input transfer is either a bus reply (mode 0) or one timer tick
// (mode 1). A reply counts only with three bytes and register field 0; it
// gives one or two key codes, bit 7 = release, 0x7e reported as 0x7f.
// Outside raw mode a press arms repeat: first repeat after repeat_delay
// ticks, later ones every repeat_period ticks; keys in the no-repeat ROM
// never arm, caps lock reports a press/release pair. With emulate_buttons
// set, button2_key/button3_key become mouse button 2/3 events, changes only.
// Each transfer yields 0..4 results on the output; last marks the final
// one. Rate: the front takes one input transfer per cycle while the bundle
// queue (two entries) has room, and all decode and repeat state update in
// that cycle. The back emits one result per cycle from the output
// register while out_ready is high; an item with no results is not queued.
// Each result passes through a queue entry and then the output register.
// Configuration sits on an APB-style port, registers at 4*index, writes
// take effect at the access phase; pready is tied high. TICK_COUNT_WIDTH
// sets the repeat counter width; larger delays saturate to its maximum.
// ----------------------------------------------------------------------------
`include "adb_key_report_decoder_defines.svh"

module adb_key_report_decoder #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  akrd_pkg::in_item_t                  in_data,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output akrd_pkg::out_item_t                 out_data,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [akrd_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [akrd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [akrd_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import akrd_pkg::*;

	cfg_t      cfg_q;
	logic      cfg_wr;
	logic [2:0] reg_idx;

	bundle_t   push_data;
	bundle_t   head;
	logic      push;
	logic      pop;
	q_status_t q_stat;

	// --- configuration registers ---
	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plain_keys <= 1'b0;
			cfg_q.repeat_delay <= RST_REPEAT_DELAY;
			cfg_q.repeat_period <= RST_REPEAT_PERIOD;
			cfg_q.emulate_buttons <= 1'b0;
			cfg_q.button2_key <= RST_BUTTON2_KEY;
			cfg_q.button3_key <= RST_BUTTON3_KEY;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PLAIN_KEYS:      cfg_q.plain_keys <= pwdata[0];
				REG_REPEAT_DELAY:    cfg_q.repeat_delay <= pwdata[15:0];
				REG_REPEAT_PERIOD:   cfg_q.repeat_period <= pwdata[15:0];
				REG_EMULATE_BUTTONS: cfg_q.emulate_buttons <= pwdata[0];
				REG_BUTTON2_KEY:     cfg_q.button2_key <= pwdata[6:0];
				REG_BUTTON3_KEY:     cfg_q.button3_key <= pwdata[6:0];
				default:             ; // no register here, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PLAIN_KEYS:      prdata = {31'd0, cfg_q.plain_keys};
			REG_REPEAT_DELAY:    prdata = {16'd0, cfg_q.repeat_delay};
			REG_REPEAT_PERIOD:   prdata = {16'd0, cfg_q.repeat_period};
			REG_EMULATE_BUTTONS: prdata = {31'd0, cfg_q.emulate_buttons};
			REG_BUTTON2_KEY:     prdata = {25'd0, cfg_q.button2_key};
			REG_BUTTON3_KEY:     prdata = {25'd0, cfg_q.button3_key};
			default:             prdata = '0;
		endcase
	end

	// --- front: accept, decode, repeat state ---
	akrd_front #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// --- bundle queue ---
	akrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// --- back: one result per transfer ---
	akrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// --- checks ---
	// nothing queued and nothing held: the output cannot show a result next cycle
	`AKRD_ASSERT_NEXT(a_no_phantom, !q_stat.nonempty && !out_valid, !out_valid)
	// retiring a bundle loads its final result, flagged as last
	`AKRD_ASSERT_NEXT(a_pop_last, pop, out_valid && out_data.last)
	// a button event carries no scan code and names button two or three
	`AKRD_ASSERT_SAME(a_btn_form, out_valid && out_data.kind == KIND_BUTTON,
		out_data.scan_code == 8'd0 &&
		(out_data.button_number == BTN_TWO || out_data.button_number == BTN_THREE))

endmodule
